// File: src/assert_macros.svh
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked at every rising edge outside reset
`define ASSERT_IMPLIES(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("same-cycle implication failed");

// next-cycle implication, checked at every rising edge outside reset
`define ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("next-cycle implication failed");

// invariant that holds at every rising edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("invariant failed");

`endif

// File: src/epsf_pkg.sv
// shared constants, types and codes of the encoder period speed filter
package epsf_pkg;

  localparam int PERIOD_BITS   = 16;
  localparam int FRACTION_BITS = 8;

  localparam int IN_PERIOD_W = 16;
  localparam int NUM_W       = 20;
  localparam int DB_W        = 16;
  localparam int GAIN_W      = 15;
  localparam int GAIN_SHIFT  = 15;
  localparam int SPEED_W     = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 20;

  localparam int DIV_CNT_W = $clog2(NUM_W);
  localparam int QS_W      = NUM_W + FRACTION_BITS;
  localparam int SUM_W     = SPEED_W + 1;
  localparam int PROD_A_W  = GAIN_W + 1 + SUM_W;
  localparam int PROD_B_W  = GAIN_W + 1 + SPEED_W;
  localparam int ACC_W     = PROD_A_W + 1;

  localparam logic [NUM_W-1:0]  NUMERATOR_RESET     = NUM_W'(120000);
  localparam logic [DB_W-1:0]   DEAD_BAND_RESET     = DB_W'(40);
  localparam logic [GAIN_W-1:0] INPUT_GAIN_RESET    = GAIN_W'(4912);
  localparam logic [GAIN_W-1:0] FEEDBACK_GAIN_RESET = GAIN_W'(22944);

  localparam logic signed [SPEED_W-1:0] SPEED_MAX = {1'b0, {(SPEED_W-1){1'b1}}};
  localparam logic signed [SPEED_W-1:0] SPEED_MIN = {1'b1, {(SPEED_W-1){1'b0}}};
  localparam logic signed [ACC_W-1:0]   ROUND_BIAS = ACC_W'(1) << (GAIN_SHIFT - 1);

  typedef enum logic [1:0] {
    OP_CAPTURE = 2'd0,
    OP_TIMEOUT = 2'd1,
    OP_SAMPLE  = 2'd2
  } epsf_op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUMERATOR     = 2'd0,
    REG_DEAD_BAND     = 2'd1,
    REG_INPUT_GAIN    = 2'd2,
    REG_FEEDBACK_GAIN = 2'd3
  } epsf_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_RAW,
    S_SUM,
    S_MULA,
    S_MULB,
    S_ADD,
    S_FIN,
    S_OUT
  } epsf_state_t;

  typedef struct packed {
    logic capture;
    logic timeout;
    logic load_div;
    logic div_step;
    logic raw;
    logic sum;
    logic mul_a;
    logic mul_b;
    logic add;
    logic fin;
    logic load_out;
  } epsf_cmd_t;

endpackage

// File: src/epsf_dp.sv
// datapath: config registers, period store, divider, filter arithmetic, output register
module epsf_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  epsf_pkg::epsf_cmd_t                  cmd,
  input  logic [epsf_pkg::IN_PERIOD_W-1:0]     period,
  input  logic                                 direction,
  input  logic                                 cfg_we,
  input  logic [epsf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [epsf_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic signed [epsf_pkg::SPEED_W-1:0]  speed
);
  import epsf_pkg::*;

  logic [NUM_W-1:0]  speed_numerator;
  logic [DB_W-1:0]   dead_band;
  logic [GAIN_W-1:0] input_gain;
  logic [GAIN_W-1:0] feedback_gain;

  logic [PERIOD_BITS-1:0] period_mag;
  logic                   period_neg;

  logic signed [SPEED_W-1:0] prev_raw;
  logic signed [SPEED_W-1:0] prev_filt;

  logic [PERIOD_BITS-1:0]     rem;
  logic [NUM_W-1:0]           quo;
  logic signed [SPEED_W-1:0]  raw_q;
  logic                       raw_zero;
  logic signed [SUM_W-1:0]    sum;
  logic signed [PROD_A_W-1:0] prod_a;
  logic signed [PROD_B_W-1:0] prod_b;
  logic signed [ACC_W-1:0]    acc;
  logic signed [SPEED_W-1:0]  filt;

  logic [PERIOD_BITS:0]       shifted;
  logic                       fits;
  logic [QS_W-1:0]            qs;
  logic [SPEED_W:0]           qs_ext;
  logic signed [SPEED_W-1:0]  raw_next;
  logic signed [ACC_W-1:0]    acc_next;
  logic signed [ACC_W-1:0]    acc_sh;
  logic signed [SPEED_W-1:0]  filt_next;
  logic signed [SPEED_W:0]    filt_ext;
  logic signed [SPEED_W:0]    filt_mag;
  logic signed [SPEED_W:0]    db_lim;
  logic                       below_band;

  // restoring division, one quotient bit per step
  assign shifted = {rem, quo[NUM_W-1]};
  assign fits    = shifted >= {1'b0, period_mag};

  // quotient to fixed point with saturation, then sign
  always_comb begin
    qs     = QS_W'(quo) << FRACTION_BITS;
    qs_ext = (SPEED_W+1)'(qs);
    if (!period_neg) begin
      raw_next = (qs_ext > (SPEED_W+1)'(SPEED_MAX)) ? SPEED_MAX : qs_ext[SPEED_W-1:0];
    end else if (qs_ext > (SPEED_W+1)'(1) << (SPEED_W-1)) begin
      raw_next = SPEED_MIN;
    end else begin
      raw_next = SPEED_W'(-qs_ext[SPEED_W-1:0]);
    end
  end

  // rounding, floor scale and saturation of the filter sum
  always_comb begin
    acc_next = ACC_W'(prod_a) + ACC_W'(prod_b) + ROUND_BIAS;
    acc_sh   = acc >>> GAIN_SHIFT;
    if (acc_sh > ACC_W'(SPEED_MAX)) begin
      filt_next = SPEED_MAX;
    end else if (acc_sh < ACC_W'(SPEED_MIN)) begin
      filt_next = SPEED_MIN;
    end else begin
      filt_next = acc_sh[SPEED_W-1:0];
    end
  end

  // deadband on the magnitude
  always_comb begin
    filt_ext   = (SPEED_W+1)'(filt);
    filt_mag   = (filt_ext < 0) ? -filt_ext : filt_ext;
    db_lim     = $signed((SPEED_W+1)'(dead_band) << FRACTION_BITS);
    below_band = filt_mag < db_lim;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_numerator <= NUMERATOR_RESET;
      dead_band       <= DEAD_BAND_RESET;
      input_gain      <= INPUT_GAIN_RESET;
      feedback_gain   <= FEEDBACK_GAIN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NUMERATOR:     speed_numerator <= cfg_data[NUM_W-1:0];
        REG_DEAD_BAND:     dead_band       <= cfg_data[DB_W-1:0];
        REG_INPUT_GAIN:    input_gain      <= cfg_data[GAIN_W-1:0];
        REG_FEEDBACK_GAIN: feedback_gain   <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      period_mag <= '0;
      period_neg <= 1'b0;
      prev_raw   <= '0;
      prev_filt  <= '0;
    end else begin
      if (cmd.capture) begin
        period_mag <= PERIOD_BITS'(period);
        period_neg <= !direction;
      end else if (cmd.timeout) begin
        period_mag <= '0;
        period_neg <= 1'b0;
      end
      if (cmd.fin) begin
        prev_raw  <= raw_zero ? '0 : raw_q;
        prev_filt <= raw_zero ? '0 : filt_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_div) begin
      rem <= '0;
      quo <= speed_numerator;
    end else if (cmd.div_step) begin
      rem <= fits ? PERIOD_BITS'(shifted - {1'b0, period_mag}) : shifted[PERIOD_BITS-1:0];
      quo <= {quo[NUM_W-2:0], fits};
    end
    if (cmd.raw) begin
      raw_q    <= raw_next;
      raw_zero <= (period_mag == '0) || (quo == '0);
    end
    if (cmd.sum) begin
      sum <= SUM_W'(raw_q) + SUM_W'(prev_raw);
    end
    if (cmd.mul_a) begin
      prod_a <= PROD_A_W'($signed({1'b0, input_gain})) * PROD_A_W'(sum);
    end
    if (cmd.mul_b) begin
      prod_b <= PROD_B_W'($signed({1'b0, feedback_gain})) * PROD_B_W'(prev_filt);
    end
    if (cmd.add) begin
      acc <= acc_next;
    end
    if (cmd.fin) begin
      filt <= raw_zero ? '0 : filt_next;
    end
    if (cmd.load_out) begin
      speed <= below_band ? '0 : filt;
    end
  end

endmodule

// File: src/epsf_ctrl.sv
// controller: sequencing state machine, divider step count and output valid
module epsf_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [1:0]           opcode,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  output epsf_pkg::epsf_cmd_t  cmd
);
  import epsf_pkg::*;

  epsf_state_t          state;
  epsf_state_t          state_next;
  logic [DIV_CNT_W-1:0] count;
  logic                 out_free;
  logic                 div_last;

  assign out_free = !out_valid || !out_stall;
  assign div_last = count == DIV_CNT_W'(NUM_W - 1);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid && opcode == OP_SAMPLE) state_next = S_DIV;
      end
      S_DIV: begin
        if (div_last) state_next = S_RAW;
      end
      S_RAW:  state_next = S_SUM;
      S_SUM:  state_next = S_MULA;
      S_MULA: state_next = S_MULB;
      S_MULB: state_next = S_ADD;
      S_ADD:  state_next = S_FIN;
      S_FIN:  state_next = S_OUT;
      S_OUT: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = state != S_IDLE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (opcode)
            OP_CAPTURE: cmd.capture  = 1'b1;
            OP_TIMEOUT: cmd.timeout  = 1'b1;
            OP_SAMPLE:  cmd.load_div = 1'b1;
            default: ;
          endcase
        end
      end
      S_DIV:  cmd.div_step = 1'b1;
      S_RAW:  cmd.raw      = 1'b1;
      S_SUM:  cmd.sum      = 1'b1;
      S_MULA: cmd.mul_a    = 1'b1;
      S_MULB: cmd.mul_b    = 1'b1;
      S_ADD:  cmd.add      = 1'b1;
      S_FIN:  cmd.fin      = 1'b1;
      S_OUT:  cmd.load_out = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_div) begin
        count <= '0;
      end else if (cmd.div_step) begin
        count <= count + DIV_CNT_W'(1);
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: src/encoder_period_speed_filter_unit.sv
// top level of the encoder period to filtered speed unit
// usage:
//   input channel (in_valid / in_stall) carries opcode, period and direction.
//   a capture item stores the period signed by direction, a timeout item clears
//   it; both act while idle and give no result. an unused opcode is dropped.
//   a sample item divides speed_numerator by the stored period, low-pass filters
//   the raw speed in q.8 and gives one speed item on the output channel.
//   a sample item runs through the 20-step restoring divider and then seven
//   single-multiply filter steps; the next item is taken only after the result
//   is loaded, so one sample is worked on at a time. a result waiting in the
//   output register does not block capture, timeout or the next sample's
//   arithmetic; only the final load waits while out_stall holds a previous
//   speed item in place. config port: cfg_we writes cfg_data to register
//   cfg_index; the user must write only while idle, the block itself does not
//   enforce it. reset (rst, synchronous) restores register defaults, clears the
//   period and both filter states, and empties the output register.
`include "assert_macros.svh"

module encoder_period_speed_filter_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  // input item channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           opcode,
  input  logic [epsf_pkg::IN_PERIOD_W-1:0]     period,
  input  logic                                 direction,
  // result item channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [epsf_pkg::SPEED_W-1:0]  speed,
  // configuration write port
  input  logic                                 cfg_we,
  input  logic [epsf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [epsf_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import epsf_pkg::*;

  // one command strobe per datapath step
  epsf_cmd_t cmd;

  // sequencing: idle accept, divide, filter steps, output load
  epsf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .opcode    (opcode),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // arithmetic, config registers, period store, filter state and speed register
  epsf_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .period    (period),
    .direction (direction),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .speed     (speed)
  );

  // the controller never issues two steps at once
  `ASSERT_ALWAYS(a_cmd_onehot, clk, rst, $onehot0(cmd))
  // a sample item holds off the input channel while it is worked on
  `ASSERT_NEXT(a_sample_busy, clk, rst, in_valid && !in_stall && opcode == OP_SAMPLE, in_stall)
  // a result never overwrites one that is still stalled
  `ASSERT_IMPLIES(a_no_overwrite, clk, rst, cmd.load_out, !out_valid || !out_stall)
  // a loaded result is presented in the next cycle
  `ASSERT_NEXT(a_load_shows, clk, rst, cmd.load_out, out_valid)

endmodule
